>>> rtl/tcp_pkg.sv
// Shared types, codes and helpers of the task cycle profiler.
package tcp_pkg;

	localparam int NAME_W = 72;
	localparam int CNT32_W = 32;
	localparam int SHARE_W = 14;
	localparam int PROD_W = CNT32_W + SHARE_W;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);
	localparam int IN_W = 112;
	localparam int OUT_W = 120;

	localparam logic [SHARE_W-1:0] FULL_SHARE = 14'd10000;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SW_IN = 2'd1;
	localparam logic [1:0] OP_SW_OUT = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	localparam logic [1:0] STAT_HIT = 2'd0;
	localparam logic [1:0] STAT_NEW = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;
	localparam logic [1:0] STAT_TZERO = 2'd3;

	typedef struct packed {
		logic [CNT32_W-1:0] switches;
		logic [CNT32_W-1:0] cycles;
		logic [CNT32_W-1:0] stamp;
		logic [7:0]         name_high;
		logic [63:0]        name_low;
	} entry_t;

	typedef struct packed {
		logic [SHARE_W-1:0] cpu;
		logic [CNT32_W-1:0] switches;
		logic [CNT32_W-1:0] cycles;
		logic               slot_valid;
		logic [3:0]         slot_used;
		logic [1:0]         status;
	} result_t;

	// Clears every byte from the first zero byte of the name onward.
	function automatic logic [NAME_W-1:0] norm_name(logic [63:0] lo, logic [7:0] hi);
		logic [NAME_W-1:0] r;
		logic seen;
		r = {hi, lo};
		seen = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (lo[8*b +: 8] == 8'd0) begin
				seen = 1'b1;
			end
			if (seen) begin
				r[8*b +: 8] = 8'd0;
			end
		end
		if (seen) begin
			r[71:64] = 8'd0;
		end
		return r;
	endfunction

endpackage

>>> rtl/task_cycle_profiler.sv
// Per-task cycle profiler: slot table in RAM, serial lookup and serial share division.
// A read uses the bit-serial divider for the CPU share and skips it when the grand total is zero.
// Throughput: one item at a time; a switch walks every slot through the single RAM
// read port, one slot per cycle, and a read waits for the divider.
// Reset clears all slot valid bits and the grand total at once; no clearing pass.
module task_cycle_profiler #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// operation, name_low, name_high, cycle_stamp, slot_index, zero pad
	input  logic [tcp_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status, slot_used, slot_valid, slot_cycles, slot_switches, cpu_hundredths,
	// total_running, zero pad
	output logic [tcp_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ENT_W = $bits(tcp_pkg::entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_SCANEND = 4'd2;
	localparam logic [3:0] S_ACT = 4'd3;
	localparam logic [3:0] S_UPD = 4'd4;
	localparam logic [3:0] S_RDREQ = 4'd5;
	localparam logic [3:0] S_RDDATA = 4'd6;
	localparam logic [3:0] S_DIVGO = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]                     state_q;
	logic [SLOT_COUNT-1:0]          valid_q;
	logic [tcp_pkg::CNT32_W-1:0]    total_q;
	logic                           found_q;
	logic                           free_q;
	logic [IDX_W-1:0]               scan_cnt_q;
	logic                           cmp_vld_s1;
	logic [IDX_W-1:0]               cmp_idx_s1;
	logic                           out_valid_q;
	logic [tcp_pkg::OUT_W-1:0]      out_data_q;

	logic [1:0]                     op_q;
	logic [tcp_pkg::NAME_W-1:0]     name_q;
	logic [tcp_pkg::CNT32_W-1:0]    stamp_q;
	logic [3:0]                     idx_q;
	logic [IDX_W-1:0]               addr_q;
	logic [IDX_W-1:0]               hit_idx_q;
	logic [IDX_W-1:0]               free_idx_q;
	tcp_pkg::entry_t                hit_ent_q;
	logic [tcp_pkg::CNT32_W-1:0]    elapsed_q;
	logic [tcp_pkg::PROD_W-1:0]     prod_q;
	tcp_pkg::result_t               res_q;

	logic [1:0]                     in_op;
	logic [3:0]                     in_idx;
	logic [6:0]                     in_idx_ext;
	logic [6:0]                     hit_idx_ext;
	logic [6:0]                     free_idx_ext;
	logic [tcp_pkg::CNT32_W-1:0]    new_cycles;
	logic [tcp_pkg::CNT32_W-1:0]    new_switches;
	logic [tcp_pkg::PROD_W-1:0]     quotient;
	logic [tcp_pkg::SHARE_W-1:0]    share_capped;
	logic                           div_done;
	logic                           div_start;
	logic                           rd_valid;
	logic [tcp_pkg::CNT32_W-1:0]    rd_cycles;
	logic [tcp_pkg::CNT32_W-1:0]    rd_switches;
	logic                           out_load;

	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	tcp_pkg::entry_t                ram_wdata;
	logic [IDX_W-1:0]               ram_raddr;
	tcp_pkg::entry_t                ram_rdata;
	logic [ENT_W-1:0]               ram_rdata_raw;

	function automatic tcp_pkg::result_t make_res(logic [1:0] status, logic [3:0] slot,
			logic slot_vld, logic [tcp_pkg::CNT32_W-1:0] cycles,
			logic [tcp_pkg::CNT32_W-1:0] switches, logic [tcp_pkg::SHARE_W-1:0] cpu);
		return {cpu, switches, cycles, slot_vld, slot, status};
	endfunction

	assign in_op = s_axis_tdata[1:0];
	assign in_idx = s_axis_tdata[109:106];
	assign in_idx_ext = 7'(in_idx);
	assign hit_idx_ext = 7'(hit_idx_q);
	assign free_idx_ext = 7'(free_idx_q);
	assign new_cycles = hit_ent_q.cycles + elapsed_q;
	assign new_switches = hit_ent_q.switches + 32'd1;
	assign share_capped = (quotient > tcp_pkg::PROD_W'(tcp_pkg::FULL_SHARE))
		? tcp_pkg::FULL_SHARE : quotient[tcp_pkg::SHARE_W-1:0];
	assign div_start = state_q == S_DIVGO;
	assign ram_rdata = tcp_pkg::entry_t'(ram_rdata_raw);
	assign ram_raddr = (state_q == S_SCAN) ? scan_cnt_q : addr_q;
	assign rd_valid = valid_q[addr_q];
	assign rd_cycles = rd_valid ? ram_rdata.cycles : '0;
	assign rd_switches = rd_valid ? ram_rdata.switches : '0;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = hit_ent_q;
		unique case (state_q)
			S_ACT: begin
				if (op_q == tcp_pkg::OP_SW_IN) begin
					if (found_q) begin
						ram_we = 1'b1;
						ram_wdata.stamp = stamp_q;
					end else if (free_q) begin
						ram_we = 1'b1;
						ram_waddr = free_idx_q;
						ram_wdata.name_low = name_q[63:0];
						ram_wdata.name_high = name_q[71:64];
						ram_wdata.stamp = stamp_q;
						ram_wdata.cycles = '0;
						ram_wdata.switches = '0;
					end
				end
			end
			S_UPD: begin
				ram_we = 1'b1;
				ram_wdata.cycles = new_cycles;
				ram_wdata.switches = new_switches;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			scan_cnt_q <= '0;
			cmp_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= state_q == S_SCAN;
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			if (cmp_vld_s1) begin
				if (valid_q[cmp_idx_s1] && !found_q
					&& {ram_rdata.name_high, ram_rdata.name_low} == name_q) begin
					found_q <= 1'b1;
					hit_idx_q <= cmp_idx_s1;
					hit_ent_q <= ram_rdata;
				end
				if (!valid_q[cmp_idx_s1] && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= cmp_idx_s1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= in_op;
						name_q <= tcp_pkg::norm_name(s_axis_tdata[65:2], s_axis_tdata[73:66]);
						stamp_q <= s_axis_tdata[105:74];
						idx_q <= in_idx;
						addr_q <= in_idx_ext[IDX_W-1:0];
						found_q <= 1'b0;
						free_q <= 1'b0;
						scan_cnt_q <= '0;
						unique case (in_op)
							tcp_pkg::OP_CLEAR: begin
								valid_q <= '0;
								total_q <= '0;
								res_q <= make_res(tcp_pkg::STAT_HIT, 4'd0, 1'b0, '0, '0, '0);
								state_q <= S_DONE;
							end
							tcp_pkg::OP_SW_IN, tcp_pkg::OP_SW_OUT: begin
								state_q <= S_SCAN;
							end
							default: begin
								if (in_idx_ext >= 7'(SLOT_COUNT)) begin
									res_q <= make_res(tcp_pkg::STAT_MISS, in_idx, 1'b0,
										'0, '0, '0);
									state_q <= S_DONE;
								end else begin
									state_q <= S_RDREQ;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					cmp_idx_s1 <= scan_cnt_q;
					if (scan_cnt_q == LAST_IDX) begin
						state_q <= S_SCANEND;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				S_SCANEND: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					if (op_q == tcp_pkg::OP_SW_IN) begin
						state_q <= S_DONE;
						if (found_q) begin
							res_q <= make_res(tcp_pkg::STAT_HIT, hit_idx_ext[3:0], 1'b1,
								hit_ent_q.cycles, hit_ent_q.switches, '0);
						end else if (free_q) begin
							valid_q[free_idx_q] <= 1'b1;
							res_q <= make_res(tcp_pkg::STAT_NEW, free_idx_ext[3:0], 1'b1,
								'0, '0, '0);
						end else begin
							res_q <= make_res(tcp_pkg::STAT_MISS, 4'd0, 1'b0, '0, '0, '0);
						end
					end else if (found_q) begin
						elapsed_q <= stamp_q - hit_ent_q.stamp;
						state_q <= S_UPD;
					end else begin
						res_q <= make_res(tcp_pkg::STAT_MISS, 4'd0, 1'b0, '0, '0, '0);
						state_q <= S_DONE;
					end
				end
				S_UPD: begin
					total_q <= total_q + elapsed_q;
					res_q <= make_res(tcp_pkg::STAT_HIT, hit_idx_ext[3:0], 1'b1,
						new_cycles, new_switches, '0);
					state_q <= S_DONE;
				end
				S_RDREQ: begin
					state_q <= S_RDDATA;
				end
				S_RDDATA: begin
					res_q <= make_res((total_q == '0) ? tcp_pkg::STAT_TZERO : tcp_pkg::STAT_HIT,
						idx_q, rd_valid, rd_cycles, rd_switches, '0);
					prod_q <= tcp_pkg::PROD_W'(rd_cycles)
						* tcp_pkg::PROD_W'(tcp_pkg::FULL_SHARE);
					if (total_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						res_q.cpu <= share_capped;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_data_q <= {3'b000, total_q, res_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	tcp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	tcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (quotient)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("A second item was accepted while one was in progress.");

	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_ACT || state_q == S_UPD))
		else $error("The slot table was written outside an update step.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW)
		else $error("The divider finished while no read was waiting for it.");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> valid_q[hit_idx_q])
		else $error("A matched slot is not marked valid.");

	a_share_capped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[84:71] <= tcp_pkg::FULL_SHARE)
		else $error("The CPU share exceeds the full share.");

endmodule

>>> rtl/tcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/tcp_div.sv
// Restoring bit-serial divider for the CPU share, one quotient bit per cycle.
module tcp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tcp_pkg::PROD_W-1:0] dividend,
	input  logic [tcp_pkg::CNT32_W-1:0] divisor,
	output logic                       done,
	output logic [tcp_pkg::PROD_W-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [tcp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [tcp_pkg::CNT32_W-1:0]   rem_q;
	logic [tcp_pkg::PROD_W-1:0]    quo_q;
	logic [tcp_pkg::CNT32_W:0]     shifted;
	logic                          fits;

	assign shifted = {rem_q, quo_q[tcp_pkg::PROD_W-1]};
	assign fits = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= tcp_pkg::DIV_CNT_W'(tcp_pkg::PROD_W);
				rem_q <= '0;
				quo_q <= dividend;
			end else if (busy_q) begin
				rem_q <= fits ? tcp_pkg::CNT32_W'(shifted - {1'b0, divisor})
					: shifted[tcp_pkg::CNT32_W-1:0];
				quo_q <= {quo_q[tcp_pkg::PROD_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tcp_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule
